### sv/fpba_pkg.sv
// Package for the fit policy block allocator.
// Holds default sizes, fit mode codes, the controller state type and the
// command and status structs. It depends on nothing else.
package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int AMOUNT_W = 16;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic load_we;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### sv/fpba_ram.sv
// Generic single write port, single read port RAM with registered read.
// It depends on nothing else.
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/fpba_ctrl.sv
// Controller of the block allocator: sequences loads, the table scan and the
// final write-back and result. It depends on fpba_pkg.
module fpba_ctrl import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic                                            req_type,
  input  status_t                                         status,
  output cmd_t                                            cmd,
  output logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] rd_addr
);

  localparam int IDX_W = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BLOCKS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_addr  = cnt;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd.start   = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.load_we = 1'b0;
    cmd.finish  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            cnt_next   = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt == LAST) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### sv/fpba_dp.sv
// Datapath of the block allocator: free size table with valid bits, the fit
// comparator, the mode register and the result register.
// It depends on fpba_pkg and fpba_ram.
module fpba_dp import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_valid,
  input  logic [MODE_W-1:0]                               fit_mode,
  input  logic [INDEX_W-1:0]                              load_index,
  input  logic [AMOUNT_W-1:0]                             amount,
  input  cmd_t                                            cmd,
  input  logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] rd_addr,
  output status_t                                         status,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic                                            granted,
  output logic [INDEX_W-1:0]                              chosen_block,
  output logic [AMOUNT_W-1:0]                             leftover
);

  localparam int IDX_W = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
  localparam int AW    = IDX_W > INDEX_W ? IDX_W : INDEX_W;
  localparam int CW    = SIZE_BITS > AMOUNT_W ? SIZE_BITS : AMOUNT_W;

  logic [MODE_W-1:0]    mode;
  logic [AMOUNT_W-1:0]  amt;
  logic [NUM_BLOCKS-1:0] vld;
  logic                 vld_q;
  logic                 cmp_v;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_left;

  logic [AW:0]          ld_wide;
  logic                 ld_ok;
  logic [AW-1:0]        ld_addr_w;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [SIZE_BITS-1:0] wdata;
  logic [CW-1:0]        load_w;
  logic [SIZE_BITS-1:0] ram_q;
  logic [SIZE_BITS-1:0] sz;
  logic [CW-1:0]        sz_w;
  logic [CW-1:0]        amt_w;
  logic [CW-1:0]        left_w;
  logic [SIZE_BITS-1:0] left;
  logic                 fits;
  logic                 better;
  logic [AW-1:0]        best_idx_w;
  logic [CW-1:0]        best_left_w;

  assign ld_wide   = (AW + 1)'(load_index);
  assign ld_ok     = ld_wide < (AW + 1)'(NUM_BLOCKS);
  assign ld_addr_w = AW'(load_index);
  assign load_w    = CW'(amount);

  always_comb begin
    if (cmd.finish) begin
      we    = found;
      waddr = best_idx;
      wdata = best_left;
    end else begin
      we    = cmd.load_we && ld_ok;
      waddr = ld_addr_w[IDX_W-1:0];
      wdata = load_w[SIZE_BITS-1:0];
    end
  end

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign sz     = vld_q ? ram_q : '0;
  assign sz_w   = CW'(sz);
  assign amt_w  = CW'(amt);
  assign left_w = sz_w - amt_w;
  assign left   = left_w[SIZE_BITS-1:0];
  assign fits   = (sz != '0) && (amt_w <= sz_w);

  always_comb begin
    case (mode)
      FIT_FIRST: better = !found;
      FIT_BEST:  better = !found || (left < best_left);
      FIT_WORST: better = !found || (left > best_left);
      default:   better = 1'b0;
    endcase
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= FIT_FIRST;
      vld       <= '0;
      cmp_v     <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= fit_mode;
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      cmp_v <= cmd.rd_en;
      if (cmd.start) begin
        found <= 1'b0;
      end else if (cmp_v && fits && better) begin
        found <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign best_idx_w  = AW'(best_idx);
  assign best_left_w = CW'(best_left);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      amt      <= amount;
      best_idx <= '0;
    end
    if (cmd.rd_en) begin
      vld_q   <= vld[rd_addr];
      cmp_idx <= rd_addr;
    end
    if (cmp_v && fits && better) begin
      best_idx  <= cmp_idx;
      best_left <= left;
    end
    if (cmd.finish) begin
      granted      <= found;
      chosen_block <= found ? best_idx_w[INDEX_W-1:0] : '0;
      leftover     <= found ? best_left_w[AMOUNT_W-1:0] : '0;
    end
  end

endmodule

### sv/fit_policy_block_allocator_unit.sv
// Top level of the fit policy block allocator.
// It depends on fpba_pkg, fpba_ctrl, fpba_dp and fpba_ram.
//
// The block keeps the free size of NUM_BLOCKS memory blocks in a RAM and
// places allocation requests under a first, best or worst fit policy.
// The input channel (in_valid, in_ready) carries one transaction per item:
// req_type selects a load of one block's size or an allocation of amount.
// The output channel (out_valid, out_ready) returns one transaction per
// allocation with granted, chosen_block and leftover; loads give none.
// The configuration channel (cfg_valid, cfg_ready) writes fit_mode; it is
// always ready and should be written only while the block is idle.
// A load is written into the table on acceptance. An allocation reads the table
// one block per cycle through the single RAM read port, then passes a drain and a finish
// state; out_valid and in_ready rise together after the finish.
// Reset sets fit_mode to first fit and marks every block empty through
// per-entry valid bits, so no clearing pass is needed.
// A result waits in the output register while the receiver stalls; loads
// are still taken, and the next allocation scans but holds its write-back
// and result until the output register is free.
module fit_policy_block_allocator_unit import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MODE_W-1:0]   fit_mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [INDEX_W-1:0]  load_index,
  input  logic [AMOUNT_W-1:0] amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                granted,
  output logic [INDEX_W-1:0]  chosen_block,
  output logic [AMOUNT_W-1:0] leftover
);

  localparam int IDX_W = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  fpba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  fpba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .fit_mode     (fit_mode),
    .load_index   (load_index),
    .amount       (amount),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .chosen_block (chosen_block),
    .leftover     (leftover)
  );

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> chosen_block == '0 && leftover == '0)
    else $error("refused result carries a nonzero block or leftover");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !in_ready)
    else $error("input accepted during a table scan");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid || out_ready)
    else $error("result overwrote one not yet taken");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.finish && cmd.load_we))
    else $error("load and write-back collide on the table");

  a_result_follows_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished allocation gave no result");

endmodule

### sim/fpba_grant_checker.sv
// Checker for the fit policy block allocator: it watches the configuration,
// input and output channels, predicts each grant and compares the results.
// It depends on fpba_pkg for field widths, fit mode codes and request kinds.
module fpba_grant_checker import fpba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [MODE_W-1:0]   fit_mode,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                req_type,
  input  logic [INDEX_W-1:0]  load_index,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                granted,
  input  logic [INDEX_W-1:0]  chosen_block,
  input  logic [AMOUNT_W-1:0] leftover,
  output int                  grants_pending,
  output int                  mismatch_count
);

  typedef struct packed {
    logic                granted;
    logic [INDEX_W-1:0]  blk;
    logic [AMOUNT_W-1:0] left;
  } grant_t;

  logic [SIZE_BITS_DEF-1:0] free_sizes [NUM_BLOCKS_DEF];
  logic [MODE_W-1:0]        policy;
  grant_t                   grants_due [$];
  int                       fails = 0;

  // Picks a block under the current policy, if one fits, and charges the request to it.
  function automatic grant_t charge_request(input logic [AMOUNT_W-1:0] req);
    grant_t                   g;
    logic                     found;
    logic [INDEX_W-1:0]       pick;
    logic [SIZE_BITS_DEF-1:0] pick_left;
    logic [SIZE_BITS_DEF-1:0] left;
    g = '0;
    found = 1'b0;
    pick = '0;
    pick_left = '0;
    if (policy == FIT_FIRST || policy == FIT_BEST || policy == FIT_WORST) begin
      for (int b = 0; b < NUM_BLOCKS_DEF; b++) begin
        if (free_sizes[b] != '0 && req <= free_sizes[b]) begin
          left = free_sizes[b] - req;
          if (!found) begin
            found = 1'b1;
            pick = INDEX_W'(b);
            pick_left = left;
          end else if ((policy == FIT_BEST && left < pick_left) ||
                       (policy == FIT_WORST && left > pick_left)) begin
            pick = INDEX_W'(b);
            pick_left = left;
          end
        end
      end
    end
    if (found) begin
      free_sizes[pick] = pick_left;
      g.granted = 1'b1;
      g.blk = pick;
      g.left = AMOUNT_W'(pick_left);
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      for (int b = 0; b < NUM_BLOCKS_DEF; b++) free_sizes[b] = '0;
      policy = FIT_FIRST;
      grants_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) policy = fit_mode;
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $error("Result transaction arrived with no allocation waiting.");
          fails++;
        end else begin
          want = grants_due.pop_front();
          if (granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, granted);
            fails++;
          end
          if (chosen_block !== want.blk) begin
            $error("chosen_block: expected %0d, actual %0d", want.blk, chosen_block);
            fails++;
          end
          if (leftover !== want.left) begin
            $error("leftover: expected %0d, actual %0d", want.left, leftover);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (req_type == REQ_LOAD) begin
          free_sizes[load_index] = amount;
        end else begin
          grants_due.push_back(charge_request(amount));
        end
      end
    end
    grants_pending <= grants_due.size();
    mismatch_count <= fails;
  end

endmodule

### sim/fit_policy_block_allocator_unit_tb.sv
// Testbench top for the fit policy block allocator: it drives loads,
// allocations and fit mode writes, and gives the verdict.
// It depends on fpba_pkg, the allocator RTL and fpba_grant_checker.
module fit_policy_block_allocator_unit_tb import fpba_pkg::*; ();

  localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 85;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MODE_W-1:0]   fit_mode = FIT_FIRST;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = REQ_LOAD;
  logic [INDEX_W-1:0]  load_index = '0;
  logic [AMOUNT_W-1:0] amount = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                granted;
  logic [INDEX_W-1:0]  chosen_block;
  logic [AMOUNT_W-1:0] leftover;

  int   grants_pending;
  int   mismatch_count;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   cycles = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int   send_pcts [4] = '{0, 45, 0, 7};
  int   recv_pcts [4] = '{0, 0, 45, 7};

  fit_policy_block_allocator_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fit_mode(fit_mode),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .load_index(load_index), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted(granted), .chosen_block(chosen_block), .leftover(leftover)
  );

  fpba_grant_checker check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fit_mode(fit_mode),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .load_index(load_index), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted(granted), .chosen_block(chosen_block), .leftover(leftover),
    .grants_pending(grants_pending), .mismatch_count(mismatch_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver stalls at random, and once holds off long enough for the
  // block to fill up and stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [INDEX_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    load_index <= idx;
    amount <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grants_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] mode);
    drain_block();
    cfg_valid <= 1'b1;
    fit_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Loads use a few coarse sizes so that ties between blocks are common.
  task automatic random_item();
    logic [AMOUNT_W-1:0] amt;
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(9))
        0:       amt = '0;
        1:       amt = '1;
        2, 3:    amt = AMOUNT_W'($urandom);
        default: amt = AMOUNT_W'($urandom_range(1, 8) * 16);
      endcase
      send_item(REQ_LOAD, INDEX_W'($urandom_range(15)), amt);
    end else begin
      case ($urandom_range(9))
        0:       amt = '0;
        1:       amt = '1;
        2:       amt = AMOUNT_W'($urandom);
        default: amt = AMOUNT_W'($urandom_range(0, 64));
      endcase
      send_item(REQ_ALLOC, INDEX_W'($urandom_range(15)), amt);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First fit on an empty table, then exact fits, zero and oversized requests.
    send_item(REQ_ALLOC, 4'd0, 16'd0);
    send_item(REQ_ALLOC, 4'd3, 16'd1);
    send_item(REQ_LOAD, 4'd5, 16'd100);
    send_item(REQ_LOAD, 4'd9, 16'd100);
    send_item(REQ_LOAD, 4'd15, 16'hFFFF);
    send_item(REQ_LOAD, 4'd0, 16'd40);
    send_item(REQ_ALLOC, 4'd0, 16'd0);
    send_item(REQ_ALLOC, 4'd0, 16'd40);
    send_item(REQ_ALLOC, 4'd0, 16'd0);
    send_item(REQ_ALLOC, 4'd15, 16'hFFFF);
    send_item(REQ_ALLOC, 4'd0, 16'd101);
    send_item(REQ_ALLOC, 4'd0, 16'd100);

    // Best fit with an exact fit tied between two blocks.
    set_mode(FIT_BEST);
    send_item(REQ_LOAD, 4'd3, 16'd50);
    send_item(REQ_LOAD, 4'd7, 16'd30);
    send_item(REQ_LOAD, 4'd12, 16'd30);
    send_item(REQ_ALLOC, 4'd0, 16'd30);
    send_item(REQ_ALLOC, 4'd0, 16'd20);
    send_item(REQ_ALLOC, 4'd0, 16'd200);

    set_mode(FIT_WORST);
    send_item(REQ_ALLOC, 4'd0, 16'd10);
    send_item(REQ_ALLOC, 4'd0, 16'd0);
    send_item(REQ_ALLOC, 4'd0, 16'd90);

    set_mode(FIT_UNUSED);
    send_item(REQ_ALLOC, 4'd0, 16'd1);
    send_item(REQ_ALLOC, 4'd0, 16'd0);

    for (int m = 0; m < 3; m++) begin
      for (int p = 0; p < 4; p++) begin
        set_mode(MODE_W'(m));
        send_idle_pct = send_pcts[p];
        recv_stall_pct <= recv_pcts[p];
        repeat (PHASE_ITEMS) random_item();
      end
    end

    set_mode(FIT_BEST);
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_request <= 1'b1;
    repeat (40) random_item();

    set_mode(FIT_UNUSED);
    send_idle_pct = 7;
    recv_stall_pct <= 7;
    repeat (30) random_item();

    drain_block();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/fpba_pkg.sv
sv/fpba_ram.sv
sv/fpba_ctrl.sv
sv/fpba_dp.sv
sv/fit_policy_block_allocator_unit.sv
sim/fpba_grant_checker.sv
sim/fit_policy_block_allocator_unit_tb.sv
